// File: rtl/tcce_pkg.sv
`default_nettype none

package tcce_pkg;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_COLUMNS    = 2'd0;
  localparam logic [1:0] REG_ROWS       = 2'd1;
  localparam logic [1:0] REG_BACKGROUND = 2'd2;
  localparam logic [1:0] REG_FOREGROUND = 2'd3;

  localparam logic [7:0] RESET_COLUMNS    = 8'd80;
  localparam logic [5:0] RESET_ROWS       = 6'd25;
  localparam logic [3:0] RESET_BACKGROUND = 4'd0;
  localparam logic [3:0] RESET_FOREGROUND = 4'd7;

  localparam logic [1:0] KIND_PRINT  = 2'd0;
  localparam logic [1:0] KIND_SCROLL = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;
  localparam logic [1:0] KIND_READ   = 2'd3;

  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_BLANK = 8'h20;

  typedef struct packed {
    logic [7:0] columns;
    logic [5:0] rows;
    logic [3:0] background;
    logic [3:0] foreground;
  } cfg_t;

  typedef struct packed {
    logic [3:0] foreground;
    logic [3:0] background;
    logic [7:0] character;
  } cell_t;

  typedef struct packed {
    logic [4:0] read_row;
    logic [6:0] read_column;
    logic [7:0] scroll_count;
    logic [7:0] character;
  } item_t;

  typedef struct packed {
    logic       did_scroll;
    logic [4:0] cursor_row;
    logic [6:0] cursor_column;
    logic [3:0] cell_foreground;
    logic [3:0] cell_background;
    logic [7:0] cell_character;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/tcce_regs.sv
`default_nettype none

module tcce_regs (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [tcce_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [tcce_pkg::DATA_W-1:0]     pwdata,
  output logic      [tcce_pkg::DATA_W-1:0]     prdata,
  output logic                                 pready,
  output tcce_pkg::cfg_t                       cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.columns    <= tcce_pkg::RESET_COLUMNS;
      cfg.rows       <= tcce_pkg::RESET_ROWS;
      cfg.background <= tcce_pkg::RESET_BACKGROUND;
      cfg.foreground <= tcce_pkg::RESET_FOREGROUND;
    end else if (wr) begin
      unique case (paddr[3:2])
        tcce_pkg::REG_COLUMNS:    cfg.columns    <= pwdata[7:0];
        tcce_pkg::REG_ROWS:       cfg.rows       <= pwdata[5:0];
        tcce_pkg::REG_BACKGROUND: cfg.background <= pwdata[3:0];
        tcce_pkg::REG_FOREGROUND: cfg.foreground <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      tcce_pkg::REG_COLUMNS:    prdata = tcce_pkg::DATA_W'(cfg.columns);
      tcce_pkg::REG_ROWS:       prdata = tcce_pkg::DATA_W'(cfg.rows);
      tcce_pkg::REG_BACKGROUND: prdata = tcce_pkg::DATA_W'(cfg.background);
      tcce_pkg::REG_FOREGROUND: prdata = tcce_pkg::DATA_W'(cfg.foreground);
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/tcce_cell_mem.sv
`default_nettype none

module tcce_cell_mem #(
  parameter int AW = 12
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire tcce_pkg::cell_t wdata,
  input  wire logic [AW-1:0]   raddr,
  output tcce_pkg::cell_t      rdata
);

  tcce_pkg::cell_t mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/tcce_ctrl.sv
`default_nettype none

module tcce_ctrl #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 32,
  parameter int TAB_STOP    = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire tcce_pkg::cfg_t cfg,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [1:0]     in_kind,
  input  wire tcce_pkg::item_t in_item,
  input  wire logic           res_full,
  output logic                emit,
  output tcce_pkg::res_t      res
);

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int AW = CW + RW;
  localparam int WW = $clog2(MAX_COLUMNS + 1);
  localparam int HW = $clog2(MAX_ROWS + 1);
  localparam int CT = $clog2(MAX_COLUMNS + TAB_STOP);
  localparam int RT = $clog2(MAX_ROWS + 2);
  localparam int TW = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_COPY  = 6'b001000,
    S_BLANK = 6'b010000,
    S_DRAIN = 6'b100000
  } state_t;

  state_t state;

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [TW-1:0] tab_pos;

  logic [RW-1:0] sn;
  logic [RW-1:0] cy;
  logic [CW-1:0] cx;
  logic [AW-1:0] ia;
  logic          wk_v;
  logic          wk_copy;
  logic [AW-1:0] wk_addr;
  logic          rd_hit;

  logic [WW-1:0] w;
  logic [HW-1:0] h;
  logic [CW-1:0] wm1;
  logic [RW-1:0] hm1;

  logic          accept;
  logic          printable;
  logic [CT-1:0] col_t;
  logic [RT-1:0] row_t;
  logic [TW-1:0] tp_t;
  logic          need_scroll;
  logic [RT-1:0] pn;
  logic          p_clear;
  logic          write_cell;
  logic          s_zero;
  logic          s_clear;
  logic [RW-1:0] s_row;
  logic          in_range;
  logic [CW-1:0] idle_col;
  logic [RW-1:0] idle_row;
  logic [RW-1:0] dst_row;

  logic            we;
  logic [AW-1:0]   waddr;
  tcce_pkg::cell_t wdata;
  logic [AW-1:0]   raddr;
  tcce_pkg::cell_t rdata;
  tcce_pkg::cell_t blank_cell;
  tcce_pkg::cell_t print_cell;

  // active geometry, zero acts as one and oversize saturates
  always_comb begin
    if (cfg.columns == 8'd0) begin
      w = WW'(1);
    end else if ({1'b0, cfg.columns} > 9'(MAX_COLUMNS)) begin
      w = WW'(MAX_COLUMNS);
    end else begin
      w = WW'(cfg.columns);
    end
    if (cfg.rows == 6'd0) begin
      h = HW'(1);
    end else if ({1'b0, cfg.rows} > 7'(MAX_ROWS)) begin
      h = HW'(MAX_ROWS);
    end else begin
      h = HW'(cfg.rows);
    end
  end

  assign wm1 = CW'(w - WW'(1));
  assign hm1 = RW'(h - HW'(1));

  assign in_ready = (state == S_IDLE) && !res_full;
  assign accept   = in_valid && in_ready;

  // cursor movement of a printed byte
  assign printable = !in_item.character[7] && (in_item.character >= tcce_pkg::CHAR_BLANK);

  always_comb begin
    col_t = CT'(col);
    row_t = RT'(row);
    tp_t  = tab_pos;
    priority if (printable) begin
      col_t = CT'(col) + CT'(1);
      tp_t  = (tab_pos == TW'(TAB_STOP - 1)) ? TW'(0) : tab_pos + TW'(1);
    end else if (in_item.character == tcce_pkg::CHAR_LF) begin
      row_t = RT'(row) + RT'(1);
    end else if (in_item.character == tcce_pkg::CHAR_CR) begin
      col_t = CT'(0);
      tp_t  = TW'(0);
    end else if (in_item.character == tcce_pkg::CHAR_TAB) begin
      col_t = CT'(col) + CT'(TAB_STOP) - CT'(tab_pos);
      tp_t  = TW'(0);
    end else begin
      tp_t  = tab_pos;
    end
    if (col_t >= CT'(w)) begin
      col_t = CT'(0);
      tp_t  = TW'(0);
      row_t = row_t + RT'(1);
    end
  end

  assign need_scroll = row_t >= RT'(h);
  assign pn          = row_t - RT'(hm1);
  assign p_clear     = pn >= RT'(h);
  assign write_cell  = printable && (WW'(col) < w) && (HW'(row) < h);

  assign s_zero  = in_item.scroll_count == 8'd0;
  assign s_clear = in_item.scroll_count >= 8'(h);
  assign s_row   = (8'(row) >= in_item.scroll_count) ?
                   row - RW'(in_item.scroll_count) : RW'(0);

  assign in_range = (9'(in_item.read_column) < 9'(MAX_COLUMNS)) &&
                    (7'(in_item.read_row) < 7'(MAX_ROWS));

  always_comb begin
    if (in_kind == tcce_pkg::KIND_PRINT) begin
      idle_col = CW'(col_t);
      idle_row = RW'(row_t);
    end else begin
      idle_col = col;
      idle_row = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_INIT;
      ia      <= '0;
      col     <= '0;
      row     <= '0;
      tab_pos <= '0;
      wk_v    <= 1'b0;
    end else begin
      wk_v <= 1'b0;
      unique case (state)
        S_INIT: begin
          ia <= ia + AW'(1);
          if (ia == {AW{1'b1}}) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            unique case (in_kind)
              tcce_pkg::KIND_PRINT: begin
                if (!need_scroll) begin
                  col     <= CW'(col_t);
                  row     <= RW'(row_t);
                  tab_pos <= tp_t;
                end else if (p_clear) begin
                  col     <= '0;
                  tab_pos <= '0;
                  row     <= hm1;
                  cy      <= '0;
                  cx      <= '0;
                  state   <= S_BLANK;
                end else begin
                  col     <= CW'(col_t);
                  tab_pos <= tp_t;
                  row     <= hm1;
                  sn      <= RW'(pn);
                  cy      <= RW'(pn);
                  cx      <= '0;
                  state   <= S_COPY;
                end
              end
              tcce_pkg::KIND_SCROLL: begin
                if (s_zero) begin
                  state <= S_IDLE;
                end else if (s_clear) begin
                  col     <= '0;
                  tab_pos <= '0;
                  row     <= hm1;
                  cy      <= '0;
                  cx      <= '0;
                  state   <= S_BLANK;
                end else begin
                  row   <= s_row;
                  sn    <= RW'(in_item.scroll_count);
                  cy    <= RW'(in_item.scroll_count);
                  cx    <= '0;
                  state <= S_COPY;
                end
              end
              tcce_pkg::KIND_CLEAR: begin
                col     <= '0;
                row     <= '0;
                tab_pos <= '0;
                cy      <= '0;
                cx      <= '0;
                state   <= S_BLANK;
              end
              tcce_pkg::KIND_READ: begin
                rd_hit <= in_range;
                state  <= S_READ;
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          state <= S_IDLE;
        end
        S_COPY: begin
          wk_v    <= 1'b1;
          wk_copy <= 1'b1;
          wk_addr <= {dst_row, cx};
          if (cx == wm1) begin
            cx <= '0;
            if (cy == hm1) begin
              state <= S_BLANK;
            end else begin
              cy <= cy + RW'(1);
            end
          end else begin
            cx <= cx + CW'(1);
          end
        end
        S_BLANK: begin
          wk_v    <= 1'b1;
          wk_copy <= 1'b0;
          wk_addr <= {cy, cx};
          if (cx == wm1) begin
            cx <= '0;
            if (cy == hm1) begin
              state <= S_DRAIN;
            end else begin
              cy <= cy + RW'(1);
            end
          end else begin
            cx <= cx + CW'(1);
          end
        end
        S_DRAIN: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_INIT;
        end
      endcase
    end
  end

  assign dst_row = cy - sn;

  assign blank_cell = '{foreground: cfg.foreground, background: cfg.background,
                        character: tcce_pkg::CHAR_BLANK};
  assign print_cell = '{foreground: cfg.foreground, background: cfg.background,
                        character: in_item.character};

  // write port: walk pipeline first, then the reset zero sweep, then prints
  always_comb begin
    if (wk_v) begin
      we    = 1'b1;
      waddr = wk_addr;
      wdata = wk_copy ? rdata : blank_cell;
    end else if (state == S_INIT) begin
      we    = 1'b1;
      waddr = ia;
      wdata = '0;
    end else begin
      we    = accept && (in_kind == tcce_pkg::KIND_PRINT) && write_cell;
      waddr = {row, col};
      wdata = print_cell;
    end
  end

  always_comb begin
    if (state == S_COPY) begin
      raddr = {cy, cx};
    end else begin
      raddr = {RW'(in_item.read_row), CW'(in_item.read_column)};
    end
  end

  tcce_cell_mem #(
    .AW (AW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    res  = '0;
    emit = 1'b0;
    priority if (state == S_READ) begin
      emit = 1'b1;
      if (rd_hit) begin
        res.cell_character  = rdata.character;
        res.cell_background = rdata.background;
        res.cell_foreground = rdata.foreground;
      end
      res.cursor_column = 7'(col);
      res.cursor_row    = 5'(row);
    end else if (state == S_DRAIN) begin
      emit              = 1'b1;
      res.cursor_column = 7'(col);
      res.cursor_row    = 5'(row);
      res.did_scroll    = 1'b1;
    end else if (state == S_IDLE) begin
      emit = accept &&
             (((in_kind == tcce_pkg::KIND_PRINT) && !need_scroll) ||
              ((in_kind == tcce_pkg::KIND_SCROLL) && s_zero));
      res.cursor_column = 7'(idle_col);
      res.cursor_row    = 5'(idle_row);
    end else begin
      emit = 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/text_console_cursor_engine.sv
`default_nettype none

// Text console with a cursor over a cell store of 2**clog2(MAX_ROWS) rows by
// 2**clog2(MAX_COLUMNS) cells, held in one synchronous memory with one write and one read
// port. After reset the block sweeps the whole store to zero, one cell a cycle (4096
// cells at the defaults), and takes no item until then; register writes are taken
// throughout. A printed byte that does not scroll, or a zero scroll, gives its result
// at once; a cell read waits for the registered memory read. A clear blanks the
// active h by w cells; a scroll by n < h copies rows n to h-1 to the top and blanks
// the last row (h, w the active rows and columns), the copy loop moving one cell a
// cycle through the memory port; a print that runs off the bottom costs the same as
// the scroll it causes. One result may wait at the output while the next item is taken.
module text_console_cursor_engine #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 32,
  parameter int TAB_STOP    = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tcce_pkg::ADDR_W-1:0] paddr,
  input  wire logic [tcce_pkg::DATA_W-1:0] pwdata,
  output logic      [tcce_pkg::DATA_W-1:0] prdata,
  output logic                             pready,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // character, scroll_count, read_column, read_row
  input  wire logic [31:0]                 s_axis_tdata,
  // kind
  input  wire logic [1:0]                  s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // cell_character, cell_background, cell_foreground, cursor_column, cursor_row,
  // did_scroll
  output logic      [31:0]                 m_axis_tdata
);

  tcce_pkg::cfg_t  cfg;
  tcce_pkg::item_t in_item;
  tcce_pkg::res_t  res;
  tcce_pkg::res_t  out_res;
  tcce_pkg::res_t  pend_res;
  logic            emit;
  logic            pend_v;

  assign in_item = tcce_pkg::item_t'(s_axis_tdata[$bits(tcce_pkg::item_t)-1:0]);

  tcce_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tcce_ctrl #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .TAB_STOP    (TAB_STOP)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_kind  (s_axis_tuser),
    .in_item  (in_item),
    .res_full (pend_v),
    .emit     (emit),
    .res      (res)
  );

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      pend_v        <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      if (pend_v) begin
        out_res       <= pend_res;
        pend_v        <= 1'b0;
        m_axis_tvalid <= 1'b1;
      end else if (emit) begin
        out_res       <= res;
        m_axis_tvalid <= 1'b1;
      end else begin
        m_axis_tvalid <= 1'b0;
      end
    end else if (emit) begin
      pend_res <= res;
      pend_v   <= 1'b1;
    end
  end

  assign m_axis_tdata = {{(32 - $bits(tcce_pkg::res_t)){1'b0}}, out_res};

endmodule

`default_nettype wire
